### sv/qvpi_pkg.sv
// Shared types, constants and a helper function for the quadrature velocity PI controller.
// No dependencies; imported by every module of the block.
package qvpi_pkg;

    localparam int CountWidth    = 16;
    localparam int DriveWidth    = 8;
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;

    // Divide-by-five of a 16-bit magnitude: (m * 0xCCCD) >> 18 is exact below 2^16.
    localparam int               Div5Shift = 18;
    localparam logic [16:0]      Div5Mult  = 17'd52429;

    // Drive and integral limits.
    localparam logic signed [DriveWidth-1:0] DriveMax = 8'sd100;
    localparam logic signed [DriveWidth-1:0] DriveMin = -8'sd100;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_VELOCITY_DEMAND = 3'd0,
        REG_GAIN_P          = 3'd1,
        REG_GAIN_I          = 3'd2,
        REG_ENCODER_MODE    = 3'd3,
        REG_MOTOR_SIDE      = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    typedef enum logic {
        MODE_SINGLE     = 1'b0,
        MODE_QUADRATURE = 1'b1
    } enc_mode_t;

    // Live configuration; target already holds velocity_demand / 5.
    typedef struct packed {
        logic signed [CountWidth-1:0] target;
        logic signed [CountWidth-1:0] gain_p;
        logic signed [CountWidth-1:0] gain_i;
        enc_mode_t                    encoder_mode;
        logic                         motor_side;
    } cfg_t;

    // Quadrature step for {last_a, last_b, a, b}. Both pins changing counts +2 on
    // either side; side B swaps the +1 and -1 entries.
    function automatic logic signed [2:0] quad_step(input logic [3:0] idx,
                                                    input logic       side_b);
        logic signed [2:0] s;
        case (idx)
            4'h0, 4'h5, 4'hA, 4'hF: s = 3'sd0;
            4'h1, 4'h7, 4'h8, 4'hE: s = side_b ? -3'sd1 : 3'sd1;
            4'h2, 4'h4, 4'hB, 4'hD: s = side_b ? 3'sd1 : -3'sd1;
            default:                s = 3'sd2;
        endcase
        return s;
    endfunction

endpackage

### sv/qvpi_encoder.sv
// Encoder position counter: quadrature table or single-channel A edge counting.
// Depends on qvpi_pkg (cfg_t, quad_step).
module qvpi_encoder
    import qvpi_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_en,
    input  logic                         enc_a,
    input  logic                         enc_b,
    input  cfg_t                         cfg,
    input  logic signed [DriveWidth-1:0] drive,
    output logic [CountWidth-1:0]        count,
    output logic [CountWidth-1:0]        count_next
);

    logic [CountWidth-1:0] count_reg;
    logic                  last_a_reg;
    logic                  last_a_next;
    logic                  last_b_reg;
    logic                  last_b_next;
    logic signed [2:0]     qstep;
    logic [CountWidth-1:0] step;

    assign qstep = quad_step({last_a_reg, last_b_reg, enc_a, enc_b}, cfg.motor_side);

    always_comb
    begin
        last_a_next = last_a_reg;
        last_b_next = last_b_reg;
        step        = '0;
        if (sample_en)
        begin
            if (cfg.encoder_mode == MODE_QUADRATURE)
            begin
                step        = {{(CountWidth-3){qstep[2]}}, qstep};
                last_a_next = enc_a;
                last_b_next = enc_b;
            end
            else if (last_a_reg != enc_a)
            begin
                // single channel: direction follows the sign of the last drive
                last_a_next = enc_a;
                if (drive > 8'sd0)
                    step = 16'd1;
                else if (drive < 8'sd0)
                    step = 16'hFFFF;
            end
        end
        count_next = count_reg + step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            last_a_reg <= 1'b0;
            last_b_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            last_a_reg <= last_a_next;
            last_b_reg <= last_b_next;
        end
    end

    assign count = count_reg;

endmodule

### sv/qvpi_pi.sv
// Velocity measurement and saturated PI loop, updated on control ticks.
// Depends on qvpi_pkg (cfg_t, drive limits).
module qvpi_pi
    import qvpi_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick_en,
    input  logic [CountWidth-1:0]        count,
    input  cfg_t                         cfg,
    output logic signed [CountWidth-1:0] velocity_next,
    output logic signed [CountWidth-1:0] error_next,
    output logic signed [DriveWidth-1:0] drive_next,
    output logic signed [DriveWidth-1:0] drive
);

    logic [CountWidth-1:0]        last_count_reg;
    logic signed [CountWidth-1:0] speed_reg;
    logic signed [CountWidth-1:0] error_reg;
    logic signed [DriveWidth-1:0] integral_reg;
    logic signed [DriveWidth-1:0] integral_next;
    logic signed [DriveWidth-1:0] drive_reg;

    logic signed [CountWidth-1:0] speed_new;
    logic signed [CountWidth-1:0] error_new;
    logic signed [CountWidth:0]   integ_sum;
    logic signed [DriveWidth-1:0] integ_new;
    logic signed [31:0]           prod_p;
    logic signed [23:0]           prod_i;
    logic signed [32:0]           cmd;
    logic signed [DriveWidth-1:0] drive_new;
    logic                         gain_i_pos;

    always_comb
    begin
        speed_new  = $signed(count - last_count_reg);
        error_new  = cfg.target - speed_new;
        gain_i_pos = !cfg.gain_i[CountWidth-1] && (cfg.gain_i != '0);

        // integral: full-width add, clip to the drive range, clear on gain_i <= 0
        integ_sum = {error_new[CountWidth-1], error_new}
                  + {{(CountWidth-DriveWidth+1){integral_reg[DriveWidth-1]}}, integral_reg};
        if (!gain_i_pos)
            integ_new = '0;
        else if (integ_sum > 17'sd100)
            integ_new = DriveMax;
        else if (integ_sum < -17'sd100)
            integ_new = DriveMin;
        else
            integ_new = integ_sum[DriveWidth-1:0];

        prod_p = cfg.gain_p * error_new;
        prod_i = cfg.gain_i * integ_new;
        cmd    = {prod_p[31], prod_p} + {{9{prod_i[23]}}, prod_i};
        if (cmd > 33'sd100)
            drive_new = DriveMax;
        else if (cmd < -33'sd100)
            drive_new = DriveMin;
        else
            drive_new = cmd[DriveWidth-1:0];

        velocity_next = tick_en ? speed_new : speed_reg;
        error_next    = tick_en ? error_new : error_reg;
        integral_next = tick_en ? integ_new : integral_reg;
        drive_next    = tick_en ? drive_new : drive_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            speed_reg      <= '0;
            error_reg      <= '0;
            integral_reg   <= '0;
            drive_reg      <= '0;
        end
        else
        begin
            if (tick_en)
                last_count_reg <= count;
            speed_reg    <= velocity_next;
            error_reg    <= error_next;
            integral_reg <= integral_next;
            drive_reg    <= drive_next;
        end
    end

    assign drive = drive_reg;

endmodule

### sv/quadrature_velocity_pi_controller.sv
// Top level of the quadrature encoder counter with PI velocity control.
// Depends on qvpi_pkg, qvpi_encoder and qvpi_pi.
//
// Usage:
//  - Input stream (s_axis_*): one transaction per encoder pin sample (tuser = 0,
//    tdata[0] = A, tdata[1] = B) or per control tick (tuser = 1, pins ignored).
//  - Output stream (m_axis_*): exactly one transaction per input transaction,
//    in order, carrying position, velocity, velocity error and drive command
//    as they stand after that input.
//  - Config port: cfg_we with cfg_index/cfg_data writes one register per cycle.
//    Write only while the block holds no pending transaction. The demand is
//    divided by five (toward zero) when written, so ticks see it ready.
//  - Path: a transaction is taken into the input register, then the output register.
//  - Throughput: one transaction per cycle while m_axis_tready stays high, samples
//    and ticks alike; the whole update (table step or PI math with two parallel
//    multipliers) sits between the input register and the output register.
//  - Stall: with m_axis_tready low, the output register holds its result and the
//    input register takes one more transaction; then s_axis_tready drops.
//  - Reset: count, velocity, error, integral and drive clear to zero; demand 0,
//    gain_p 0, gain_i 1, quadrature mode, side A. No transaction is pending.
module quadrature_velocity_pi_controller
    import qvpi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // [0] enc_a, [1] enc_b, rest zero
    input  logic                     s_axis_tuser,   // [0] operation

    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [55:0]              m_axis_tdata,   // [15:0] position, [31:16] velocity,
                                                     // [47:32] velocity_error,
                                                     // [55:48] drive_command

    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    // configuration
    logic signed [CountWidth-1:0] target_reg;
    logic signed [CountWidth-1:0] gain_p_reg;
    logic signed [CountWidth-1:0] gain_i_reg;
    enc_mode_t                    mode_reg;
    logic                         side_reg;
    cfg_t                         cfg;

    // demand / 5 toward zero, via reciprocal multiply on the magnitude
    logic                         dem_neg;
    logic [CountWidth-1:0]        dem_mag;
    logic [32:0]                  dem_prod;
    logic [CountWidth-1:0]        dem_quot;
    logic signed [CountWidth-1:0] target_next;

    // input and output stages
    logic                         in_valid_reg;
    logic                         in_valid_next;
    op_t                          in_op_reg;
    logic                         in_a_reg;
    logic                         in_b_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [55:0]                  out_data_reg;
    logic                         s_accept;
    logic                         advance;
    logic                         sample_en;
    logic                         tick_en;

    logic [CountWidth-1:0]        count;
    logic [CountWidth-1:0]        count_next;
    logic signed [CountWidth-1:0] velocity_next;
    logic signed [CountWidth-1:0] error_next;
    logic signed [DriveWidth-1:0] drive_next;
    logic signed [DriveWidth-1:0] drive;

    always_comb
    begin
        dem_neg     = cfg_data[CfgDataWidth-1];
        dem_mag     = dem_neg ? (~cfg_data + 16'd1) : cfg_data;
        dem_prod    = dem_mag * Div5Mult;
        dem_quot    = {1'b0, dem_prod[32:Div5Shift]};
        target_next = dem_neg ? $signed(~dem_quot + 16'd1) : $signed(dem_quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            gain_p_reg <= '0;
            gain_i_reg <= 16'sd1;
            mode_reg   <= MODE_QUADRATURE;
            side_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_VELOCITY_DEMAND: target_reg <= target_next;
                REG_GAIN_P:          gain_p_reg <= cfg_data;
                REG_GAIN_I:          gain_i_reg <= cfg_data;
                REG_ENCODER_MODE:    mode_reg   <= enc_mode_t'(cfg_data[0]);
                REG_MOTOR_SIDE:      side_reg   <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        cfg.target       = target_reg;
        cfg.gain_p       = gain_p_reg;
        cfg.gain_i       = gain_i_reg;
        cfg.encoder_mode = mode_reg;
        cfg.motor_side   = side_reg;
    end

    // Handshake: the input register moves on whenever the output slot is free
    // or being drained this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign sample_en     = advance && (in_op_reg == OP_SAMPLE);
    assign tick_en       = advance && (in_op_reg == OP_TICK);

    always_comb
    begin
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_op_reg <= op_t'(s_axis_tuser);
            in_a_reg  <= s_axis_tdata[0];
            in_b_reg  <= s_axis_tdata[1];
        end
        if (advance)
            out_data_reg <= {drive_next, error_next, velocity_next, count_next};
    end

    qvpi_encoder u_encoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_en  (sample_en),
        .enc_a      (in_a_reg),
        .enc_b      (in_b_reg),
        .cfg        (cfg),
        .drive      (drive),
        .count      (count),
        .count_next (count_next)
    );

    qvpi_pi u_pi (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_en       (tick_en),
        .count         (count),
        .cfg           (cfg),
        .velocity_next (velocity_next),
        .error_next    (error_next),
        .drive_next    (drive_next),
        .drive         (drive)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### test/tb.sv
// Self-checking testbench for quadrature_velocity_pi_controller: encoder counting,
// velocity measurement and the saturated PI drive, checked against an in-bench model.
// Depends on qvpi_pkg and the RTL of the block; needs no other file.
`timescale 1ns / 1ps

module tb;
    import qvpi_pkg::*;

    localparam int DrainLimit   = 2000;      // cycles allowed for outstanding results
    localparam int RunLimitNs   = 5_000_000; // hard stop for a hung run
    localparam int PrintLimit   = 100;       // mismatch lines printed at most
    localparam int RandomPhases = 8;
    localparam int PhaseItems   = 190;

    // Expected contents of one output transaction, lowest tdata bits last.
    typedef struct packed {
        logic signed [7:0]  drive_command;
        logic signed [15:0] velocity_error;
        logic signed [15:0] velocity;
        logic signed [15:0] position;
    } drive_status_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;

    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata = '0;    // [0] enc_a, [1] enc_b, rest zero
    logic                     s_axis_tuser = 1'b0;  // [0] operation

    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [55:0]              m_axis_tdata;         // [15:0] position, [31:16] velocity,
                                                    // [47:32] velocity_error,
                                                    // [55:48] drive_command

    logic                     cfg_we = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_data = '0;

    quadrature_velocity_pi_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Model of the block: register shadows and controller state, all at
    // their reset values.
    // ------------------------------------------------------------------
    logic signed [15:0] demand_set  = 16'sd0;
    logic signed [15:0] kp_set      = 16'sd0;
    logic signed [15:0] ki_set      = 16'sd1;
    enc_mode_t          mode_set    = MODE_QUADRATURE;
    logic               mirror_set  = 1'b0;

    logic [15:0]        enc_count     = '0;
    logic [15:0]        count_at_tick = '0;
    logic [15:0]        speed         = '0;
    logic [15:0]        speed_error   = '0;
    logic               pin_a_seen    = 1'b0;
    logic               pin_b_seen    = 1'b0;
    int                 integral_acc  = 0;
    int                 drive_level   = 0;

    drive_status_t      pending_status[$];   // one entry per accepted input transaction
    int                 error_count = 0;

    // Stimulus pacing shared between the tests and the two bus processes.
    int                 burst_left   = 0;
    bit                 sender_gaps  = 1'b1;
    int                 stall_style  = 0;    // 0 always ready, 1 light, 2 one in three, 3 heavy
    int                 hold_request = 0;    // long receiver hold-off, picked up by receiver
    int                 hold_left    = 0;
    int                 rx_phase     = 0;
    logic [1:0]         pins         = 2'b00; // {a, b} last driven on a sample

    task automatic report_error(string msg);
        error_count++;
        // Keep the log readable on a badly broken build; every error still counts.
        if (error_count <= PrintLimit)
            $display("[%0t] ERROR %s", $realtime, msg);
    endtask

    // Next pin pair along the Gray sequence 00 -> 01 -> 11 -> 10 (forward) or back.
    function automatic logic [1:0] gray_step(logic [1:0] p, bit fwd);
        case (p)
            2'b00:   return fwd ? 2'b01 : 2'b10;
            2'b01:   return fwd ? 2'b11 : 2'b00;
            2'b11:   return fwd ? 2'b10 : 2'b01;
            default: return fwd ? 2'b00 : 2'b11;
        endcase
    endfunction

    // Count change for one quadrature transition. Forward Gray steps count up on
    // side A and down on side B; a double change is an invalid jump, always +2.
    function automatic int quad_delta(logic [1:0] was, logic [1:0] now, logic mirrored);
        if (was == now)
            return 0;
        if ((was ^ now) == 2'b11)
            return 2;
        if (now == gray_step(was, 1'b1))
            return mirrored ? -1 : 1;
        return mirrored ? 1 : -1;
    endfunction

    // Advance the model by one accepted transaction and queue the status it shows.
    task automatic predict_status(op_t op, logic a, logic b);
        int            target;
        int            err;
        longint        cmd;
        drive_status_t s;
        if (op == OP_TICK)
        begin
            // Pins are ignored on a tick. Integer division truncates toward zero.
            target        = int'(demand_set) / 5;
            speed         = enc_count - count_at_tick;
            count_at_tick = enc_count;
            speed_error   = 16'(target - int'($signed(speed)));
            err           = int'($signed(speed_error));
            if (ki_set > 0)
                integral_acc += err;
            else
                integral_acc = 0;
            if (integral_acc > 100)
                integral_acc = 100;
            else if (integral_acc < -100)
                integral_acc = -100;
            cmd = longint'(kp_set) * err + longint'(ki_set) * integral_acc;
            if (cmd > 100)
                cmd = 100;
            else if (cmd < -100)
                cmd = -100;
            drive_level = int'(cmd);
        end
        else if (mode_set == MODE_SINGLE)
        begin
            // Only A edges count, by the sign of the drive; B is not tracked.
            if (pin_a_seen != a)
            begin
                if (drive_level > 0)
                    enc_count = enc_count + 16'd1;
                else if (drive_level < 0)
                    enc_count = enc_count - 16'd1;
                pin_a_seen = a;
            end
        end
        else
        begin
            enc_count  = enc_count + 16'(quad_delta({pin_a_seen, pin_b_seen}, {a, b},
                                                    mirror_set));
            pin_a_seen = a;
            pin_b_seen = b;
        end
        s.position       = enc_count;
        s.velocity       = speed;
        s.velocity_error = speed_error;
        s.drive_command  = 8'(drive_level);
        pending_status.push_back(s);
    endtask

    // ------------------------------------------------------------------
    // Receiver: compares every output transaction with the oldest expected
    // status, then decides tready for the next cycle. Long hold-offs are
    // counted here.
    // ------------------------------------------------------------------
    task automatic check_status(logic [55:0] bus);
        drive_status_t want;
        if (pending_status.size() == 0)
        begin
            report_error($sformatf("output transaction with nothing expected: %h", bus));
            return;
        end
        want = pending_status.pop_front();
        if (bus[15:0] !== want.position)
            report_error($sformatf("position: got %0d, expected %0d",
                                   $signed(bus[15:0]), want.position));
        if (bus[31:16] !== want.velocity)
            report_error($sformatf("velocity: got %0d, expected %0d",
                                   $signed(bus[31:16]), want.velocity));
        if (bus[47:32] !== want.velocity_error)
            report_error($sformatf("velocity_error: got %0d, expected %0d",
                                   $signed(bus[47:32]), want.velocity_error));
        if (bus[55:48] !== want.drive_command)
            report_error($sformatf("drive_command: got %0d, expected %0d",
                                   $signed(bus[55:48]), want.drive_command));
    endtask

    always @(posedge clk)
    begin
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            check_status(m_axis_tdata);
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        rx_phase = (rx_phase + 1) % 3;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (stall_style)
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= (rx_phase == 0);
                3:       m_axis_tready <= ($urandom_range(0, 1) != 0);
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender. Called right after a rising edge; returns at the edge where the
    // transaction was taken, with tvalid still high, so the next call can
    // follow back to back. Gaps between bursts drop tvalid.
    // ------------------------------------------------------------------
    task automatic send_item(op_t op, logic a, logic b);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps)
                gap = $urandom_range(0, 6);
        end
        burst_left--;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, b, a};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        predict_status(op, a, b);
    endtask

    // Stop offering and let every expected result come out; bounded.
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0 && waited < DrainLimit)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_status.size() != 0)
        begin
            report_error($sformatf("%0d expected results never arrived",
                                   pending_status.size()));
            pending_status.delete();
        end
        @(posedge clk);
    endtask

    // One register write, only while the block is idle.
    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_VELOCITY_DEMAND: demand_set = value;
            REG_GAIN_P:          kp_set     = value;
            REG_GAIN_I:          ki_set     = value;
            REG_ENCODER_MODE:    mode_set   = enc_mode_t'(value[0]);
            REG_MOTOR_SIDE:      mirror_set = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_sample(logic [1:0] ab);
        pins = ab;
        send_item(OP_SAMPLE, ab[1], ab[0]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (quadrature, side A). The pin sequence walks through all
    // sixteen previous/present pairs once, double changes included, and ends
    // back at 00. The ticks carry pins that must be ignored.
    task automatic test_transition_table();
        int seq[16] = '{1, 0, 2, 0, 3, 1, 1, 2, 1, 3, 2, 2, 3, 3, 0, 0};
        for (int i = 0; i < 16; i++)
            send_sample(2'(seq[i]));
        send_item(OP_TICK, 1'b1, 1'b1);
        send_sample(2'b01);
        send_item(OP_TICK, 1'b0, 1'b1);
        wait_drained();
    endtask

    // Single-channel counting: positive drive, negative drive and zero drive.
    // B toggles alongside without being recorded.
    task automatic test_single_channel();
        write_reg(REG_ENCODER_MODE, 16'(MODE_SINGLE));
        write_reg(REG_GAIN_P, 16'sd1);
        write_reg(REG_GAIN_I, 16'sd0);
        write_reg(REG_VELOCITY_DEMAND, 16'sd500);
        send_item(OP_TICK, 1'b0, 1'b0);       // drive goes positive
        send_sample(2'b11);
        send_sample(2'b01);
        send_sample(2'b00);
        send_item(OP_TICK, 1'b0, 1'b0);
        wait_drained();
        write_reg(REG_VELOCITY_DEMAND, -16'sd500);
        send_item(OP_TICK, 1'b1, 1'b0);       // drive goes negative
        send_sample(2'b10);
        send_sample(2'b00);
        wait_drained();
        write_reg(REG_GAIN_P, 16'sd0);
        send_item(OP_TICK, 1'b0, 1'b0);       // zero drive: edges recorded, no count
        send_sample(2'b11);
        send_sample(2'b00);
        wait_drained();
        write_reg(REG_ENCODER_MODE, 16'(MODE_QUADRATURE));
    endtask

    // Command and integral clipping at the register extremes, integral clear
    // for zero and negative gain_i, and truncation of the demand toward zero.
    task automatic test_drive_limits();
        write_reg(REG_VELOCITY_DEMAND, 16'sh7FFF);
        write_reg(REG_GAIN_P, 16'sh7FFF);
        write_reg(REG_GAIN_I, 16'sh7FFF);
        send_item(OP_TICK, 1'b0, 1'b0);
        send_item(OP_TICK, 1'b0, 1'b0);
        wait_drained();
        write_reg(REG_VELOCITY_DEMAND, 16'sh8000);
        write_reg(REG_GAIN_P, 16'sh8000);
        send_item(OP_TICK, 1'b0, 1'b0);
        wait_drained();
        write_reg(REG_GAIN_I, 16'sh8000);
        send_item(OP_TICK, 1'b0, 1'b0);
        wait_drained();
        write_reg(REG_VELOCITY_DEMAND, -16'sd7); // target -1
        write_reg(REG_GAIN_P, -16'sd1);
        write_reg(REG_GAIN_I, 16'sd0);
        send_item(OP_TICK, 1'b0, 1'b0);
        wait_drained();
        write_reg(REG_VELOCITY_DEMAND, 16'sd30);
        write_reg(REG_GAIN_P, 16'sd0);
        write_reg(REG_GAIN_I, 16'sd1);
        for (int i = 0; i < 4; i++)
            send_item(OP_TICK, 1'b0, 1'b0);   // integral ramps toward its limit
        wait_drained();
        write_reg(REG_VELOCITY_DEMAND, -16'sd4); // target 0
        send_item(OP_TICK, 1'b0, 1'b0);
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering:
    // the block fills and must stall its input without losing anything.
    task automatic test_output_backpressure();
        bit fwd;
        fwd         = 1'b1;
        stall_style = 0;
        sender_gaps = 1'b0;
        hold_request = 300;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 10 == 9)
                send_item(OP_TICK, 1'b0, 1'b0);
            else
                send_sample(gray_step(pins, fwd));
        end
        wait_drained();
        sender_gaps = 1'b1;
    endtask

    // Random phases. Each writes all five registers (extremes in the first two),
    // then drives mostly clean Gray walks with direction changes, occasional
    // ticks, held pins and some pin noise with double changes.
    task automatic test_random_traffic();
        bit fwd;
        int r;
        fwd = 1'b1;
        for (int p = 0; p < RandomPhases; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(REG_VELOCITY_DEMAND, 16'sh7FFF);
                    write_reg(REG_GAIN_P, 16'sh7FFF);
                    write_reg(REG_GAIN_I, 16'sh7FFF);
                    write_reg(REG_ENCODER_MODE, 16'(MODE_QUADRATURE));
                    write_reg(REG_MOTOR_SIDE, 16'd0);
                end
                1:
                begin
                    write_reg(REG_VELOCITY_DEMAND, 16'sh8000);
                    write_reg(REG_GAIN_P, 16'sh8000);
                    write_reg(REG_GAIN_I, 16'sh8000);
                    write_reg(REG_ENCODER_MODE, 16'(MODE_QUADRATURE));
                    write_reg(REG_MOTOR_SIDE, 16'd1);
                end
                default:
                begin
                    // Small gains, and small demands but in phase 5, let the drive swing through
                    // both signs and zero, so single-channel counting sees each.
                    if (p == 5)
                        write_reg(REG_VELOCITY_DEMAND, 16'($urandom));
                    else
                        write_reg(REG_VELOCITY_DEMAND,
                                  16'(int'($urandom_range(0, 400)) - 200));
                    write_reg(REG_GAIN_P, 16'(int'($urandom_range(0, 6)) - 3));
                    write_reg(REG_GAIN_I, 16'(int'($urandom_range(0, 5)) - 2));
                    write_reg(REG_ENCODER_MODE,
                              (p % 3 == 2) ? 16'(MODE_SINGLE) : 16'(MODE_QUADRATURE));
                    write_reg(REG_MOTOR_SIDE, 16'($urandom_range(0, 1)));
                end
            endcase
            stall_style = p % 4;
            sender_gaps = (p != 3);
            for (int i = 0; i < PhaseItems; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 7)
                begin
                    send_item(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                else if (r < 15)
                begin
                    send_sample(2'($urandom_range(0, 3)));
                end
                else if (r < 22)
                begin
                    send_sample(pins);
                end
                else
                begin
                    if ($urandom_range(0, 29) == 0)
                        fwd = !fwd;
                    send_sample(gray_step(pins, fwd));
                end
            end
            wait_drained();
        end
        stall_style = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_transition_table();
        test_single_channel();
        test_drive_limits();
        test_output_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("quadrature_velocity_pi_controller regression: pass");
        else
            $display("quadrature_velocity_pi_controller regression: fail");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #(RunLimitNs);
        $display("quadrature_velocity_pi_controller regression: fail");
        $finish;
    end

endmodule
